// ----- rtl/core/stbw_pkg.sv -----
// Shared constants and codes for the ST-map bilinear image warp.
package stbw_pkg;

    localparam int MAP_AW   = 14;              // address bits of one map bank (128 x 128)
    localparam int SRC_AW   = 18;              // address bits of one frame bank (512 x 512)
    localparam int FIFO_AW  = 4;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;
    localparam int DIV_STEPS  = 24;            // quotient bits of the map scale

    localparam logic [10:0] IMG_DIM = 11'd1024;
    localparam logic [8:0]  MAP_DIM = 9'd256;

    typedef enum logic [1:0] {
        CMD_MAP  = 2'b00,
        CMD_PIX  = 2'b01,
        CMD_WARP = 2'b10
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_SRC_W   = 3'd0,
        CFG_SRC_H   = 3'd1,
        CFG_OUT_W   = 3'd2,
        CFG_OUT_H   = 3'd3,
        CFG_MAP_W   = 3'd4,
        CFG_MAP_H   = 3'd5,
        CFG_WARP_EN = 3'd6
    } cfg_idx_t;

endpackage

// ----- rtl/core/stmap_bilinear_image_warp.sv -----
// ST-map bilinear warp of an RGB888 frame: banked stores, sample pipeline, output queue.
// A warp item raises m_tvalid once its result is written into the output queue.
// Throughput: one item per cycle while s_tready is high; the four bilinear reads of each store
// hit four parity banks. s_tready stays low after a configuration write and after reset release
// (scale divider, one quotient bit a cycle), and while 16 results are outstanding (queue depth).
// Reset: synchronous, active low; registers return to defaults, stores are not cleared.
module stmap_bilinear_image_warp
    import stbw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // col[9:0], row[19:10], map_u[39:20], map_v[59:40], in_red[67:60],
    // in_green[75:68], in_blue[83:76], zero fill[87:84]
    input  logic [87:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_wdata
);

    // ------------------------------------------------------------------
    // Arithmetic helpers
    // ------------------------------------------------------------------
    // a + floor((b - a) * t / 2^16) on Q16 map values
    function automatic logic [19:0] lerp_m(input logic signed [19:0] a,
                                           input logic signed [19:0] b,
                                           input logic [15:0] t);
        logic signed [20:0] d;
        logic signed [37:0] p;
        logic signed [21:0] q;
        logic signed [21:0] s;
        d = b - a;
        p = d * $signed({1'b0, t});
        q = $signed(p[37:16]);
        s = a + q;
        return s[19:0];
    endfunction

    // c0 * 2^16 + (c1 - c0) * f, exact and never negative
    function automatic logic [23:0] blend_h(input logic [7:0] c0, input logic [7:0] c1,
                                            input logic [15:0] f);
        logic signed [8:0]  d;
        logic signed [25:0] p;
        logic signed [25:0] s;
        d = $signed({1'b0, c1}) - $signed({1'b0, c0});
        p = d * $signed({1'b0, f});
        s = $signed({2'b0, c0, 16'h0}) + p;
        return s[23:0];
    endfunction

    // vertical blend in Q32, add one half, floor; the result stays within 0..255
    function automatic logic [7:0] blend_v(input logic [23:0] t, input logic [23:0] b,
                                           input logic [15:0] f);
        logic signed [24:0] d;
        logic signed [41:0] p;
        logic signed [41:0] s;
        d = $signed({1'b0, b}) - $signed({1'b0, t});
        p = d * $signed({1'b0, f});
        s = $signed({2'b0, t, 16'h0}) + p + 42'sd2147483648;
        return s[39:32];
    endfunction

    // one restoring division step: {remainder, shifted dividend with quotient bit}
    function automatic logic [33:0] div_step(input logic [9:0] rem, input logic [23:0] num,
                                             input logic [9:0] den);
        logic [10:0] rs;
        rs = {rem, num[23]};
        if (rs >= {1'b0, den}) begin
            return {10'(rs - {1'b0, den}), num[22:0], 1'b1};
        end
        return {rs[9:0], num[22:0], 1'b0};
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [10:0] src_w_reg, src_h_reg, out_w_reg, out_h_reg;
    logic [8:0]  map_w_reg, map_h_reg;
    logic        warp_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg   <= IMG_DIM;
            src_h_reg   <= IMG_DIM;
            out_w_reg   <= IMG_DIM;
            out_h_reg   <= IMG_DIM;
            map_w_reg   <= '0;
            map_h_reg   <= '0;
            warp_en_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SRC_W:   src_w_reg   <= cfg_wdata;
                CFG_SRC_H:   src_h_reg   <= cfg_wdata;
                CFG_OUT_W:   out_w_reg   <= cfg_wdata;
                CFG_OUT_H:   out_h_reg   <= cfg_wdata;
                CFG_MAP_W:   map_w_reg   <= cfg_wdata[8:0];
                CFG_MAP_H:   map_h_reg   <= cfg_wdata[8:0];
                CFG_WARP_EN: warp_en_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Saturate the sizes once; the user (not the block) keeps them still with items in flight
    logic [10:0] sw, sh, ow, oh;
    logic [8:0]  mw, mh;
    logic [9:0]  sw_m1, sh_m1, ow_m1, oh_m1, ox, oy;
    logic [7:0]  mw_m1, mh_m1;
    logic        copy_mode;

    always_comb begin
        sw = (src_w_reg == '0) ? 11'd1 : ((src_w_reg > IMG_DIM) ? IMG_DIM : src_w_reg);
        sh = (src_h_reg == '0) ? 11'd1 : ((src_h_reg > IMG_DIM) ? IMG_DIM : src_h_reg);
        ow = (out_w_reg == '0) ? 11'd1 : ((out_w_reg > IMG_DIM) ? IMG_DIM : out_w_reg);
        oh = (out_h_reg == '0) ? 11'd1 : ((out_h_reg > IMG_DIM) ? IMG_DIM : out_h_reg);
        mw = (map_w_reg > MAP_DIM) ? MAP_DIM : map_w_reg;
        mh = (map_h_reg > MAP_DIM) ? MAP_DIM : map_h_reg;
        sw_m1 = 10'(sw - 11'd1);
        sh_m1 = 10'(sh - 11'd1);
        ow_m1 = 10'(ow - 11'd1);
        oh_m1 = 10'(oh - 11'd1);
        mw_m1 = 8'(mw - 9'd1);
        mh_m1 = 8'(mh - 9'd1);
        // centre-crop offset, zero when the output is wider than the source
        ox = (sw > ow) ? 10'((sw - ow) >> 1) : '0;
        oy = (sh > oh) ? 10'((sh - oh) >> 1) : '0;
        copy_mode = !warp_en_reg || (mw == '0) || (mh == '0);
    end

    // ------------------------------------------------------------------
    // Map scale divider: ((map_dim - 1) << 16) / (out_dim - 1), restarted
    // after reset and after every configuration write
    // ------------------------------------------------------------------
    logic        div_start_reg;
    logic [4:0]  div_cnt_reg;
    logic [23:0] dx_num_reg, dy_num_reg;
    logic [9:0]  dx_rem_reg, dy_rem_reg;
    logic [33:0] dx_next, dy_next;
    logic        div_busy;
    logic [23:0] scx, scy;

    assign dx_next  = div_step(dx_rem_reg, dx_num_reg, ow_m1);
    assign dy_next  = div_step(dy_rem_reg, dy_num_reg, oh_m1);
    assign div_busy = div_start_reg || (div_cnt_reg != '0);
    // an output size of one gives a scale of zero
    assign scx = (ow_m1 == '0) ? '0 : dx_num_reg;
    assign scy = (oh_m1 == '0) ? '0 : dy_num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_start_reg <= 1'b1;
            div_cnt_reg   <= '0;
        end else begin
            div_start_reg <= cfg_we;
            if (div_start_reg) begin
                div_cnt_reg <= 5'(DIV_STEPS);
            end else if (div_cnt_reg != '0) begin
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_start_reg) begin
            dx_num_reg <= {mw_m1, 16'h0};
            dy_num_reg <= {mh_m1, 16'h0};
            dx_rem_reg <= '0;
            dy_rem_reg <= '0;
        end else if (div_cnt_reg != '0) begin
            {dx_rem_reg, dx_num_reg} <= dx_next;
            {dy_rem_reg, dy_num_reg} <= dy_next;
        end
    end

    // ------------------------------------------------------------------
    // Input handshake and result credit
    // ------------------------------------------------------------------
    logic [FIFO_AW:0] cnt_reg, fcnt_reg;
    logic             acc, pop, fifo_push;

    assign s_tready = !div_busy && (cnt_reg < (FIFO_AW + 1)'(FIFO_DEPTH));
    assign acc      = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_reg + (FIFO_AW + 1)'(acc && (s_tuser == CMD_WARP))
                               - (FIFO_AW + 1)'(pop);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: valid and command travel with each item
    // ------------------------------------------------------------------
    logic [7:0] vld_reg;
    cmd_t       cmd_reg [8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[6:0], acc};
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg[0] <= cmd_t'(s_tuser);
        for (int i = 1; i < 8; i++) begin
            cmd_reg[i] <= cmd_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: capture the item
    // Stage 1: scale the position into the map; work out the crop position
    // ------------------------------------------------------------------
    logic [9:0]  col_reg [6];
    logic [9:0]  row_reg [6];
    logic [23:0] rgb_reg [6];
    logic        cp_reg  [6];
    logic [39:0] uv0_reg, uv1_reg;
    logic [9:0]  cx_reg [1:5];
    logic [9:0]  cy_reg [1:5];
    logic [33:0] mx_reg, my_reg;
    logic [10:0] csum_x, csum_y;

    assign csum_x = {1'b0, col_reg[0]} + {1'b0, ox};
    assign csum_y = {1'b0, row_reg[0]} + {1'b0, oy};

    always_ff @(posedge aclk) begin
        col_reg[0] <= s_tdata[9:0];
        row_reg[0] <= s_tdata[19:10];
        uv0_reg    <= s_tdata[59:20];
        rgb_reg[0] <= s_tdata[83:60];
        cp_reg[0]  <= copy_mode;
        for (int i = 1; i < 6; i++) begin
            col_reg[i] <= col_reg[i-1];
            row_reg[i] <= row_reg[i-1];
            rgb_reg[i] <= rgb_reg[i-1];
            cp_reg[i]  <= cp_reg[i-1];
        end
        uv1_reg   <= uv0_reg;
        mx_reg    <= 34'(col_reg[0]) * 34'(scx);
        my_reg    <= 34'(row_reg[0]) * 34'(scy);
        // clamp the cropped position to the last source column and row
        cx_reg[1] <= (csum_x > {1'b0, sw_m1}) ? sw_m1 : csum_x[9:0];
        cy_reg[1] <= (csum_y > {1'b0, sh_m1}) ? sh_m1 : csum_y[9:0];
        for (int i = 2; i < 6; i++) begin
            cx_reg[i] <= cx_reg[i-1];
            cy_reg[i] <= cy_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: clamp into the map, pick the four neighbours, access the map
    // banks. Banks split by column and row parity, so the two columns (and
    // rows) of a neighbourhood always sit in different banks unless clamped
    // onto the same entry. Loads write here too, so reads and writes keep
    // item order.
    // ------------------------------------------------------------------
    logic [23:0]       mx, my, mx_lim, my_lim;
    logic [7:0]        mx0, mx1, my0, my1;
    logic [MAP_AW-1:0] map_raddr [4];
    logic [MAP_AW-1:0] map_waddr;
    logic [1:0]        map_wbank;
    logic              map_we;
    logic [39:0]       map_q [4];
    logic [15:0]       tx2_reg, ty2_reg, ty3_reg;
    logic              mpx0_reg, mpx1_reg, mpy0_reg, mpy1_reg;

    always_comb begin
        mx_lim = {mw_m1, 16'h0};
        my_lim = {mh_m1, 16'h0};
        mx  = (mx_reg > 34'(mx_lim)) ? mx_lim : mx_reg[23:0];
        my  = (my_reg > 34'(my_lim)) ? my_lim : my_reg[23:0];
        mx0 = mx[23:16];
        my0 = my[23:16];
        mx1 = (mx0 == mw_m1) ? mx0 : mx0 + 8'd1;
        my1 = (my0 == mh_m1) ? my0 : my0 + 8'd1;
        for (int b = 0; b < 4; b++) begin
            map_raddr[b] = {((my0[0] == b[1]) ? my0[7:1] : my1[7:1]),
                            ((mx0[0] == b[0]) ? mx0[7:1] : mx1[7:1])};
        end
        // drop map loads outside the store
        map_we    = vld_reg[1] && (cmd_reg[1] == CMD_MAP) &&
                    (col_reg[1][9:8] == 2'b00) && (row_reg[1][9:8] == 2'b00);
        map_wbank = {row_reg[1][0], col_reg[1][0]};
        map_waddr = {row_reg[1][7:1], col_reg[1][7:1]};
    end

    for (genvar b = 0; b < 4; b++) begin : g_map_bank
        logic [39:0] mem [1 << MAP_AW];
        always_ff @(posedge aclk) begin
            if (map_we && (map_wbank == 2'(b))) begin
                mem[map_waddr] <= uv1_reg;
            end
            map_q[b] <= mem[map_raddr[b]];
        end
    end

    always_ff @(posedge aclk) begin
        tx2_reg  <= mx[15:0];
        ty2_reg  <= my[15:0];
        mpx0_reg <= mx0[0];
        mpx1_reg <= mx1[0];
        mpy0_reg <= my0[0];
        mpy1_reg <= my1[0];
    end

    // ------------------------------------------------------------------
    // Stage 3: horizontal map lerp. Stage 4: vertical map lerp.
    // ------------------------------------------------------------------
    logic [39:0]        q00, q10, q01, q11;
    logic signed [19:0] ut3_reg, ub3_reg, vt3_reg, vb3_reg, u4_reg, v4_reg;

    assign q00 = map_q[{mpy0_reg, mpx0_reg}];
    assign q10 = map_q[{mpy0_reg, mpx1_reg}];
    assign q01 = map_q[{mpy1_reg, mpx0_reg}];
    assign q11 = map_q[{mpy1_reg, mpx1_reg}];

    always_ff @(posedge aclk) begin
        ut3_reg <= $signed(lerp_m($signed(q00[19:0]),  $signed(q10[19:0]),  tx2_reg));
        ub3_reg <= $signed(lerp_m($signed(q01[19:0]),  $signed(q11[19:0]),  tx2_reg));
        vt3_reg <= $signed(lerp_m($signed(q00[39:20]), $signed(q10[39:20]), tx2_reg));
        vb3_reg <= $signed(lerp_m($signed(q01[39:20]), $signed(q11[39:20]), tx2_reg));
        ty3_reg <= ty2_reg;
        u4_reg  <= $signed(lerp_m(ut3_reg, ub3_reg, ty3_reg));
        v4_reg  <= $signed(lerp_m(vt3_reg, vb3_reg, ty3_reg));
    end

    // ------------------------------------------------------------------
    // Stage 5: U,V to source position, V flipped
    // ------------------------------------------------------------------
    logic signed [20:0] vinv;
    logic signed [30:0] sxr5_reg;
    logic signed [31:0] syr5_reg;

    assign vinv = 21'sd65536 - v4_reg;

    always_ff @(posedge aclk) begin
        sxr5_reg <= u4_reg * $signed({1'b0, sw_m1});
        syr5_reg <= vinv * $signed({1'b0, sh_m1});
    end

    // ------------------------------------------------------------------
    // Stage 6: clamp into the source, access the frame banks. Copy items
    // read one pixel with zero weights so the blend passes it through.
    // ------------------------------------------------------------------
    logic [25:0]       sx, sy;
    logic [9:0]        sx0, sx1, sy0, sy1;
    logic [15:0]       fx, fy;
    logic [SRC_AW-1:0] src_raddr [4];
    logic [SRC_AW-1:0] src_waddr;
    logic [1:0]        src_wbank;
    logic              src_we;
    logic [23:0]       src_q [4];
    logic [15:0]       fx6_reg, fy6_reg, fy7_reg;
    logic              spx0_reg, spx1_reg, spy0_reg, spy1_reg;

    always_comb begin
        if (sxr5_reg < 0) begin
            sx = '0;
        end else if (sxr5_reg > $signed({5'b0, sw_m1, 16'h0})) begin
            sx = {sw_m1, 16'h0};
        end else begin
            sx = sxr5_reg[25:0];
        end
        if (syr5_reg < 0) begin
            sy = '0;
        end else if (syr5_reg > $signed({6'b0, sh_m1, 16'h0})) begin
            sy = {sh_m1, 16'h0};
        end else begin
            sy = syr5_reg[25:0];
        end
        if (cp_reg[5]) begin
            sx0 = cx_reg[5];
            sx1 = cx_reg[5];
            sy0 = cy_reg[5];
            sy1 = cy_reg[5];
            fx  = '0;
            fy  = '0;
        end else begin
            sx0 = sx[25:16];
            sy0 = sy[25:16];
            sx1 = (sx0 == sw_m1) ? sx0 : sx0 + 10'd1;
            sy1 = (sy0 == sh_m1) ? sy0 : sy0 + 10'd1;
            fx  = sx[15:0];
            fy  = sy[15:0];
        end
        for (int b = 0; b < 4; b++) begin
            src_raddr[b] = {((sy0[0] == b[1]) ? sy0[9:1] : sy1[9:1]),
                            ((sx0[0] == b[0]) ? sx0[9:1] : sx1[9:1])};
        end
        src_we    = vld_reg[5] && (cmd_reg[5] == CMD_PIX);
        src_wbank = {row_reg[5][0], col_reg[5][0]};
        src_waddr = {row_reg[5][9:1], col_reg[5][9:1]};
    end

    for (genvar b = 0; b < 4; b++) begin : g_src_bank
        logic [23:0] mem [1 << SRC_AW];
        always_ff @(posedge aclk) begin
            if (src_we && (src_wbank == 2'(b))) begin
                mem[src_waddr] <= rgb_reg[5];
            end
            src_q[b] <= mem[src_raddr[b]];
        end
    end

    always_ff @(posedge aclk) begin
        fx6_reg  <= fx;
        fy6_reg  <= fy;
        spx0_reg <= sx0[0];
        spx1_reg <= sx1[0];
        spy0_reg <= sy0[0];
        spy1_reg <= sy1[0];
    end

    // ------------------------------------------------------------------
    // Stage 7: horizontal pixel blend per channel
    // ------------------------------------------------------------------
    logic [23:0] p00, p10, p01, p11;
    logic [23:0] top7_reg [3];
    logic [23:0] bot7_reg [3];

    assign p00 = src_q[{spy0_reg, spx0_reg}];
    assign p10 = src_q[{spy0_reg, spx1_reg}];
    assign p01 = src_q[{spy1_reg, spx0_reg}];
    assign p11 = src_q[{spy1_reg, spx1_reg}];

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 3; c++) begin
            top7_reg[c] <= blend_h(p00[8*c +: 8], p10[8*c +: 8], fx6_reg);
            bot7_reg[c] <= blend_h(p01[8*c +: 8], p11[8*c +: 8], fx6_reg);
        end
        fy7_reg <= fy6_reg;
    end

    // ------------------------------------------------------------------
    // Vertical blend, round and hold the result in the output queue
    // ------------------------------------------------------------------
    logic [23:0]        fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [23:0]        res_next;

    assign fifo_push = vld_reg[7] && (cmd_reg[7] == CMD_WARP);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            res_next[8*c +: 8] = blend_v(top7_reg[c], bot7_reg[c], fy7_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (fifo_push) begin
            fifo_mem[wr_ptr_reg] <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fcnt_reg   <= '0;
        end else begin
            if (fifo_push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            fcnt_reg <= fcnt_reg + (FIFO_AW + 1)'(fifo_push) - (FIFO_AW + 1)'(pop);
        end
    end

    assign m_tvalid = (fcnt_reg != '0);
    assign m_tdata  = fifo_mem[rd_ptr_reg];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("outstanding results exceed the output queue depth");

    a_queue_within_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= cnt_reg)
        else $error("output queue holds more items than were accepted");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_push |-> ((fcnt_reg != (FIFO_AW + 1)'(FIFO_DEPTH)) || pop))
        else $error("result pushed into a full output queue");

    a_div_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("item accepted while the map scale is recomputed");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the ST-map bilinear image warp.
module tb
    import stbw_pkg::*;
();

    localparam logic [1:0] CMD_NONE = 2'b11;   // unused command, no result
    localparam int IDLE_LIMIT = 4000;           // cycles without any handshake

    // Predicts output pixels from the accepted items and checks the results in order.
    class warp_scoreboard;
        logic [10:0] src_w, src_h, out_w, out_h;
        logic [8:0]  map_w, map_h;
        logic        warp_en;
        longint      map_u[int];
        longint      map_v[int];
        logic [23:0] frame[int];                // {red, green, blue}
        logic [23:0] pixel_q[$];                // {blue, green, red} as on m_tdata
        int          errors;
        int          n_warps;

        function new();
            src_w = 11'd1024; src_h = 11'd1024; out_w = 11'd1024; out_h = 11'd1024;
            map_w = 9'd0; map_h = 9'd0; warp_en = 1'b0;
            errors = 0; n_warps = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [10:0] val);
            case (idx)
                CFG_SRC_W:   src_w = val;
                CFG_SRC_H:   src_h = val;
                CFG_OUT_W:   out_w = val;
                CFG_OUT_H:   out_h = val;
                CFG_MAP_W:   map_w = val[8:0];
                CFG_MAP_H:   map_h = val[8:0];
                CFG_WARP_EN: warp_en = val[0];
                default: ;
            endcase
        endfunction

        function longint clampl(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function longint sat_dim(longint d);
            return clampl(d, 1, 1024);
        endfunction

        function logic [23:0] pixel_at(longint x, longint y);
            int a;
            a = int'(y * 1024 + x);
            if (x >= 1024 || y >= 1024 || !frame.exists(a)) return 24'd0;
            return frame[a];
        endfunction

        // floor division by 2^16 on the blended value
        function longint lerp(longint a, longint b, longint t);
            return (a * 65536 + (b - a) * t) >>> 16;
        endfunction

        function void note_item(logic [1:0] cmd, logic [87:0] d);
            longint col, row, sw, sh, ow, oh, mw, mh;
            longint scx, scy, mx, my, x0, y0, x1, y1, tx, ty;
            longint ut, ub, vt, vb, u, v, sx, sy, sx0, sy0, sx1, sy1, fx, fy;
            longint c00, c10, c01, c11, top, bot, val, r;
            logic [23:0] p00, p10, p01, p11, res;
            col = d[9:0]; row = d[19:10];
            sw = sat_dim(src_w); sh = sat_dim(src_h);
            ow = sat_dim(out_w); oh = sat_dim(out_h);
            mw = (map_w > 256) ? 256 : map_w;
            mh = (map_h > 256) ? 256 : map_h;
            if (cmd == CMD_MAP) begin
                if (col < 256 && row < 256) begin
                    map_u[int'(row * 256 + col)] = longint'($signed(d[39:20]));
                    map_v[int'(row * 256 + col)] = longint'($signed(d[59:40]));
                end
                return;
            end
            if (cmd == CMD_PIX) begin
                frame[int'(row * 1024 + col)] = {d[67:60], d[75:68], d[83:76]};
                return;
            end
            if (cmd != CMD_WARP) return;
            n_warps++;
            if (!warp_en || mw == 0 || mh == 0) begin
                // centre crop; offset saturates at zero, position clamps to the frame
                sx = col + ((sw > ow) ? (sw - ow) / 2 : 0);
                sy = row + ((sh > oh) ? (sh - oh) / 2 : 0);
                p00 = pixel_at(clampl(sx, 0, sw - 1), clampl(sy, 0, sh - 1));
                pixel_q.push_back({p00[7:0], p00[15:8], p00[23:16]});
                return;
            end
            scx = (ow > 1) ? ((mw - 1) << 16) / (ow - 1) : 0;
            scy = (oh > 1) ? ((mh - 1) << 16) / (oh - 1) : 0;
            mx = clampl(col * scx, 0, (mw - 1) << 16);
            my = clampl(row * scy, 0, (mh - 1) << 16);
            x0 = mx >>> 16; y0 = my >>> 16;
            x1 = (x0 + 1 > mw - 1) ? mw - 1 : x0 + 1;
            y1 = (y0 + 1 > mh - 1) ? mh - 1 : y0 + 1;
            tx = mx & 65535; ty = my & 65535;
            ut = lerp(map_u[int'(y0*256+x0)], map_u[int'(y0*256+x1)], tx);
            ub = lerp(map_u[int'(y1*256+x0)], map_u[int'(y1*256+x1)], tx);
            vt = lerp(map_v[int'(y0*256+x0)], map_v[int'(y0*256+x1)], tx);
            vb = lerp(map_v[int'(y1*256+x0)], map_v[int'(y1*256+x1)], tx);
            u = lerp(ut, ub, ty); v = lerp(vt, vb, ty);
            // V is flipped: a V of zero lands on the last source row
            sx = clampl(u * (sw - 1), 0, (sw - 1) << 16);
            sy = clampl((65536 - v) * (sh - 1), 0, (sh - 1) << 16);
            sx0 = sx >>> 16; sy0 = sy >>> 16;
            sx1 = (sx0 + 1 > sw - 1) ? sw - 1 : sx0 + 1;
            sy1 = (sy0 + 1 > sh - 1) ? sh - 1 : sy0 + 1;
            fx = sx & 65535; fy = sy & 65535;
            p00 = pixel_at(sx0, sy0); p10 = pixel_at(sx1, sy0);
            p01 = pixel_at(sx0, sy1); p11 = pixel_at(sx1, sy1);
            for (int c = 0; c < 3; c++) begin
                c00 = p00[16-8*c +: 8]; c10 = p10[16-8*c +: 8];
                c01 = p01[16-8*c +: 8]; c11 = p11[16-8*c +: 8];
                top = c00 * 65536 + (c10 - c00) * fx;
                bot = c01 * 65536 + (c11 - c01) * fx;
                val = top * 65536 + (bot - top) * fy;
                r = clampl((val + (longint'(1) << 31)) >>> 32, 0, 255);
                res[8*c +: 8] = r[7:0];
            end
            pixel_q.push_back(res);
        endfunction

        function void check_pixel(logic [23:0] got);
            logic [23:0] want;
            if (pixel_q.size() == 0) begin
                $error("unexpected output pixel %h", got);
                errors++;
                return;
            end
            want = pixel_q.pop_front();
            if (got[7:0] !== want[7:0]) begin
                $error("out_red: expected %0d, got %0d", want[7:0], got[7:0]);
                errors++;
            end
            if (got[15:8] !== want[15:8]) begin
                $error("out_green: expected %0d, got %0d", want[15:8], got[15:8]);
                errors++;
            end
            if (got[23:16] !== want[23:16]) begin
                $error("out_blue: expected %0d, got %0d", want[23:16], got[23:16]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_NONE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_SRC_W;
    logic [10:0] cfg_wdata = '0;

    warp_scoreboard sb = new();
    int  send_idle_pct = 0;         // chance of a gap before an item
    int  recv_idle_pct = 0;         // chance of m_tready low in a cycle
    bit  hold_req = 1'b0;           // ask the receiver for a long hold-off
    int  idle_cycles = 0;

    // current phase dimensions, mirrored for the stimulus
    int  sw, sh, ow, oh, mw, mh;

    always #4 aclk = ~aclk;

    stmap_bilinear_image_warp DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Monitor: note accepted items before checking results of the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_pixel(m_tdata);
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request so the queue fills.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (120) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one item; hold it until accepted, valid stays high into the next item.
    task automatic send_item(logic [1:0] cmd, int col, int row, int u, int v, int rgb);
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, rgb[7:0], rgb[15:8], rgb[23:16], v[19:0], u[19:0],
                     row[9:0], col[9:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic go_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pixel_q.size() != 0) @(negedge aclk);
        // let items with no result drain from the pipeline
        repeat (16) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[10:0];
        @(posedge aclk);
        sb.set_reg(idx, val[10:0]);
    endtask

    task automatic set_phase(int a, int b, int c, int d, int e, int f, int en);
        go_idle();
        sw = a; sh = b; ow = c; oh = d; mw = e; mh = f;
        write_reg(CFG_SRC_W, a);   write_reg(CFG_SRC_H, b);
        write_reg(CFG_OUT_W, c);   write_reg(CFG_OUT_H, d);
        write_reg(CFG_MAP_W, e);   write_reg(CFG_MAP_H, f);
        write_reg(CFG_WARP_EN, en);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly sensible map values that land inside the source, some wild ones.
    function automatic int map_value();
        if ($urandom_range(9) < 8) return $urandom_range(65536 + 8192) - 4096;
        return $urandom;
    endfunction

    // Write every map entry and source pixel this phase can read.
    task automatic fill_stores();
        for (int y = 0; y < sh; y++)
            for (int x = 0; x < sw; x++)
                send_item(CMD_PIX, x, y, 0, 0, $urandom);
        if (mw > 0 && mh > 0)
            for (int y = 0; y < mh; y++)
                for (int x = 0; x < mw; x++)
                    send_item(CMD_MAP, x, y, map_value(), map_value(), 0);
    endtask

    task automatic random_items(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 60) begin
                if ($urandom_range(9) < 7)
                    send_item(CMD_WARP, $urandom_range(ow + 1), $urandom_range(oh + 1),
                              $urandom, $urandom, $urandom);
                else
                    send_item(CMD_WARP, $urandom_range(1023), $urandom_range(1023),
                              $urandom, $urandom, $urandom);
            end else if (k < 75 && mw > 0 && mh > 0) begin
                send_item(CMD_MAP, $urandom_range(mw - 1), $urandom_range(mh - 1),
                          map_value(), map_value(), $urandom);
            end else if (k < 85) begin
                send_item(CMD_PIX, $urandom_range(sw - 1), $urandom_range(sh - 1),
                          $urandom, $urandom, $urandom);
            end else if (k < 90) begin
                // map load outside the map store: dropped
                send_item(CMD_MAP, $urandom_range(1023, 256), $urandom_range(1023),
                          $urandom, $urandom, $urandom);
            end else if (k < 95) begin
                send_item(CMD_NONE, $urandom_range(1023), $urandom_range(1023),
                          $urandom, $urandom, $urandom);
            end else begin
                send_item(CMD_PIX, $urandom_range(1023), $urandom_range(1023),
                          $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // receiver stalls more than the sender idles, then the other way round
        send_idle_pct = 38; recv_idle_pct = 53;

        // copy mode with no map
        set_phase(8, 6, 8, 6, 0, 0, 0);
        fill_stores();
        random_items(30);

        // copy mode with a valid map but warp off; output smaller, so it crops
        set_phase(12, 9, 5, 4, 4, 3, 0);
        fill_stores();
        random_items(30);

        // warp with output larger than the map; directed corners first
        set_phase(4, 3, 10, 10, 3, 3, 1);
        fill_stores();
        send_item(CMD_MAP, 0, 0, -524288, 524287, 0);
        send_item(CMD_MAP, 2, 2, 524287, -524288, 0);
        send_item(CMD_MAP, 1, 1, 0, 65536, 0);
        send_item(CMD_PIX, 0, 0, 0, 0, 24'h000000);
        send_item(CMD_PIX, 3, 2, 0, 0, 24'hffffff);
        send_item(CMD_PIX, 1023, 1023, 0, 0, 24'ha5c3f0);
        send_item(CMD_WARP, 0, 0, 0, 0, 0);
        send_item(CMD_WARP, 1023, 1023, 0, 0, 0);
        send_item(CMD_WARP, 9, 9, 0, 0, 0);
        send_item(CMD_WARP, 4, 5, 0, 0, 0);
        send_item(CMD_NONE, 1023, 1023, -1, -1, 24'hffffff);
        send_item(CMD_MAP, 300, 1023, 12345, 6789, 0);
        send_item(CMD_WARP, 1, 1, 0, 0, 0);
        random_items(30);

        send_idle_pct = 53; recv_idle_pct = 38;

        // wide source and output, one row; one-row map
        set_phase(32, 1, 32, 1, 16, 1, 1);
        fill_stores();
        random_items(30);

        // tall source and output, one column; one-column map
        set_phase(1, 32, 1, 32, 1, 16, 1);
        fill_stores();
        random_items(30);

        // warp on but map height zero: falls back to copy
        set_phase(6, 6, 6, 6, 5, 0, 1);
        fill_stores();
        random_items(30);

        send_idle_pct = 0; recv_idle_pct = 0;

        // plain warp at full rate; hold the receiver off so the input stalls
        set_phase(8, 8, 8, 8, 4, 4, 1);
        fill_stores();
        hold_req = 1'b1;
        random_items(40);

        // output of one pixel: map scale is zero
        set_phase(2, 2, 1, 1, 2, 2, 1);
        fill_stores();
        random_items(30);

        go_idle();
        $display("tb: %0d warp requests checked over eight settings", sb.n_warps);
        $display("tb: copy, crop, warp, empty map and single-pixel output covered");
        if (sb.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
